/* rtl/core/bf16lt_pkg.sv */
// Shared constants, operation codes and a rounding helper for the bf16 log table block.
package bf16lt_pkg;

  localparam int ROW_ENTRIES_C  = 256;
  localparam int MANT_ENTRIES_C = 128;
  localparam int MANT_BITS_C    = 7;

  localparam logic [31:0] DEFAULT_NAN_C = 32'hffc0_0000;
  localparam logic [31:0] QUIET_BIT_C   = 32'h0040_0000;

  typedef enum logic [1:0] {
    OP_EVAL    = 2'd0,
    OP_ROW_WR  = 2'd1,
    OP_MANT_WR = 2'd2
  } op_t;

  // Round a single-precision pattern to bf16, nearest even; NaN goes quiet.
  function automatic logic [15:0] fp32_to_bf16(input logic [31:0] w);
    logic [31:0] t;
    begin
      t = w + 32'h0000_7fff + {31'b0, w[16]};
      if (w[30:23] == 8'hff && w[22:0] != 23'b0) begin
        fp32_to_bf16 = w[31:16] | 16'h0040;
      end else begin
        fp32_to_bf16 = t[31:16];
      end
    end
  endfunction

endpackage

/* rtl/core/bf16_log_two_table_sum.sv */
// Top level: table-based bf16 natural log with a pipelined four-limb fp32 sum.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | operation, table_index, limb_select,
//          |           |                      | limb_bits, x_bits
//  out_    | output    | out_valid / out_ready| log_bits, out_of_range
//
// One item enters per cycle while the output is not stalled; an evaluation result
// passes through the table read on the edge that takes its beat, then three adders of
// three stages each and one output register. Writes and unused codes leave the
// pipeline as bubbles.
// The whole pipeline advances together; a stalled output freezes every stage.
// Reset clears only the valid bits; table contents stay undefined until written.
module bf16_log_two_table_sum import bf16lt_pkg::*; #(
  parameter int ROW_ENTRIES  = ROW_ENTRIES_C,
  parameter int MANT_ENTRIES = MANT_ENTRIES_C
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_table_index,
  input  logic        in_limb_select,
  input  logic [15:0] in_limb_bits,
  input  logic [15:0] in_x_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_log_bits,
  output logic        out_out_of_range
);

  localparam int ROW_AW  = $clog2(ROW_ENTRIES);
  localparam int MANT_AW = $clog2(MANT_ENTRIES);

  logic en, acc, row_wr, mant_wr;
  logic out_valid_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign acc      = in_valid && en;
  assign row_wr   = acc && (in_operation == OP_ROW_WR);
  assign mant_wr  = acc && (in_operation == OP_MANT_WR)
                    && ({24'b0, in_table_index} < 32'(MANT_ENTRIES));

  logic [ROW_AW-1:0]  row_idx;
  logic [MANT_AW-1:0] mant_idx;
  logic               oor_nxt;

  assign row_idx  = in_x_bits[MANT_BITS_C +: ROW_AW];
  assign mant_idx = in_x_bits[MANT_AW-1:0];
  assign oor_nxt  = in_x_bits[15] || (row_idx == '0)
                    || (row_idx == ROW_AW'(ROW_ENTRIES - 1));

  logic [15:0] row_lg, row_sm, mant_lg, mant_sm;

  bf16lt_ram #(.WIDTH(16), .DEPTH(ROW_ENTRIES)) u_row_lg (
    .clk(clk), .we(row_wr && !in_limb_select), .waddr(in_table_index[ROW_AW-1:0]),
    .wdata(in_limb_bits), .re(en), .raddr(row_idx), .rdata(row_lg)
  );
  bf16lt_ram #(.WIDTH(16), .DEPTH(ROW_ENTRIES)) u_row_sm (
    .clk(clk), .we(row_wr && in_limb_select), .waddr(in_table_index[ROW_AW-1:0]),
    .wdata(in_limb_bits), .re(en), .raddr(row_idx), .rdata(row_sm)
  );
  bf16lt_ram #(.WIDTH(16), .DEPTH(MANT_ENTRIES)) u_mant_lg (
    .clk(clk), .we(mant_wr && !in_limb_select), .waddr(in_table_index[MANT_AW-1:0]),
    .wdata(in_limb_bits), .re(en), .raddr(mant_idx), .rdata(mant_lg)
  );
  bf16lt_ram #(.WIDTH(16), .DEPTH(MANT_ENTRIES)) u_mant_sm (
    .clk(clk), .we(mant_wr && in_limb_select), .waddr(in_table_index[MANT_AW-1:0]),
    .wdata(in_limb_bits), .re(en), .raddr(mant_idx), .rdata(mant_sm)
  );

  logic v1_r, oor1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= acc && (in_operation == OP_EVAL);
    end
    if (en) begin
      oor1_r <= oor_nxt;
    end
  end

  // First add against +0: negative zero becomes +0, NaN goes quiet.
  logic [31:0] a0, s1;

  always_comb begin
    a0 = {row_sm, 16'b0};
    if (a0[30:23] == 8'hff && a0[22:0] != 23'b0) begin
      s1 = a0 | QUIET_BIT_C;
    end else if (a0 == 32'h8000_0000) begin
      s1 = 32'b0;
    end else begin
      s1 = a0;
    end
  end

  logic        v2, v3, v4;
  logic [31:0] sum2, sum3, sum4;
  logic [32:0] tag2;
  logic [16:0] tag3;
  logic        tag4;

  bf16lt_fadd #(.TAG_W(33)) u_add1 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v1_r),
    .a(s1), .b({row_lg, 16'b0}), .in_tag({oor1_r, mant_sm, mant_lg}),
    .out_valid(v2), .sum(sum2), .out_tag(tag2)
  );
  bf16lt_fadd #(.TAG_W(17)) u_add2 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v2),
    .a(sum2), .b({tag2[31:16], 16'b0}), .in_tag({tag2[32], tag2[15:0]}),
    .out_valid(v3), .sum(sum3), .out_tag(tag3)
  );
  bf16lt_fadd #(.TAG_W(1)) u_add3 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v3),
    .a(sum3), .b({tag3[15:0], 16'b0}), .in_tag(tag3[16]),
    .out_valid(v4), .sum(sum4), .out_tag(tag4)
  );

  logic [15:0] log_r;
  logic        oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v4;
    end
    if (en) begin
      log_r <= tag4 ? 16'b0 : fp32_to_bf16(sum4);
      oor_r <= tag4;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_log_bits     = log_r;
  assign out_out_of_range = oor_r;

endmodule

/* rtl/core/bf16lt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bf16lt_ram import bf16lt_pkg::*; #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/bf16lt_fadd.sv */
// Three-stage single-precision adder, round to nearest even, with a side tag.
module bf16lt_fadd import bf16lt_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [31:0]      a,
  input  logic [31:0]      b,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [31:0]      sum,
  output logic [TAG_W-1:0] out_tag
);

  // ---------------- stage A: specials, swap, align, add ----------------
  logic        a_nan, b_nan, a_inf, b_inf, swap;
  logic        spec_nxt;
  logic [31:0] spec_val_nxt;
  logic [31:0] lg, sm;
  logic [7:0]  el, es, d;
  logic [26:0] mlx, msx, alx, lost_mask;
  logic        stk;
  logic [27:0] sum_nxt;

  always_comb begin
    a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'b0);
    b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'b0);
    a_inf = (a[30:23] == 8'hff) && (a[22:0] == 23'b0);
    b_inf = (b[30:23] == 8'hff) && (b[22:0] == 23'b0);
    spec_nxt     = 1'b1;
    spec_val_nxt = a;
    if (a_nan) begin
      spec_val_nxt = a | QUIET_BIT_C;
    end else if (b_nan) begin
      spec_val_nxt = b | QUIET_BIT_C;
    end else if (a_inf && b_inf && (a[31] != b[31])) begin
      spec_val_nxt = DEFAULT_NAN_C;
    end else if (a_inf) begin
      spec_val_nxt = a;
    end else if (b_inf) begin
      spec_val_nxt = b;
    end else begin
      spec_nxt = 1'b0;
    end

    swap = b[30:0] > a[30:0];
    lg   = swap ? b : a;
    sm   = swap ? a : b;
    el   = (lg[30:23] == 8'b0) ? 8'd1 : lg[30:23];
    es   = (sm[30:23] == 8'b0) ? 8'd1 : sm[30:23];
    d    = el - es;
    mlx  = {(lg[30:23] != 8'b0), lg[22:0], 3'b000};
    msx  = {(sm[30:23] != 8'b0), sm[22:0], 3'b000};
    lost_mask = 27'b0;
    stk       = 1'b0;
    if (d >= 8'd27) begin
      alx = {26'b0, (msx != 27'b0)};
    end else begin
      lost_mask = ~({27{1'b1}} << d[4:0]);
      stk       = (msx & lost_mask) != 27'b0;
      alx       = (msx >> d[4:0]) | {26'b0, stk};
    end
    if (lg[31] ^ sm[31]) begin
      sum_nxt = {1'b0, mlx} - {1'b0, alx};
    end else begin
      sum_nxt = {1'b0, mlx} + {1'b0, alx};
    end
  end

  logic             va_r;
  logic             spec_a_r, sign_a_r, zsign_a_r;
  logic [31:0]      spec_val_a_r;
  logic [7:0]       e_a_r;
  logic [27:0]      sum_a_r;
  logic [TAG_W-1:0] tag_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
    if (en) begin
      spec_a_r     <= spec_nxt;
      spec_val_a_r <= spec_val_nxt;
      sign_a_r     <= lg[31];
      zsign_a_r    <= a[31] & b[31];
      e_a_r        <= el;
      sum_a_r      <= sum_nxt;
      tag_a_r      <= in_tag;
    end
  end

  // ---------------- stage B: leading-zero count ----------------
  logic [4:0] lz_nxt;

  always_comb begin
    lz_nxt = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (sum_a_r[i]) begin
        lz_nxt = 5'(26 - i);
      end
    end
  end

  logic             vb_r;
  logic             spec_b_r, sign_b_r, zsign_b_r;
  logic [31:0]      spec_val_b_r;
  logic [7:0]       e_b_r;
  logic [27:0]      sum_b_r;
  logic [4:0]       lz_b_r;
  logic [TAG_W-1:0] tag_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
    if (en) begin
      spec_b_r     <= spec_a_r;
      spec_val_b_r <= spec_val_a_r;
      sign_b_r     <= sign_a_r;
      zsign_b_r    <= zsign_a_r;
      e_b_r        <= e_a_r;
      sum_b_r      <= sum_a_r;
      lz_b_r       <= lz_nxt;
      tag_b_r      <= tag_a_r;
    end
  end

  // ---------------- stage C: normalize and round ----------------
  logic [26:0] nv;
  logic [8:0]  ne;
  logic [7:0]  sh;
  logic [7:0]  e_enc;
  logic        up, sgn;
  logic [30:0] mag;
  logic [31:0] res_nxt;

  always_comb begin
    sh = 8'b0;
    if (sum_b_r[27]) begin
      nv = {sum_b_r[27:2], sum_b_r[1] | sum_b_r[0]};
      ne = {1'b0, e_b_r} + 9'd1;
    end else begin
      sh = ({3'b0, lz_b_r} < e_b_r) ? {3'b0, lz_b_r} : (e_b_r - 8'd1);
      nv = sum_b_r[26:0] << sh[4:0];
      ne = {1'b0, e_b_r} - {1'b0, sh};
    end
    e_enc = nv[26] ? ne[7:0] : 8'b0;
    up    = nv[2] & (nv[3] | nv[1] | nv[0]);
    mag   = {e_enc, nv[25:3]} + {30'b0, up};
    sgn   = (sum_b_r == 28'b0) ? zsign_b_r : sign_b_r;
    if (spec_b_r) begin
      res_nxt = spec_val_b_r;
    end else if (ne >= 9'd255) begin
      res_nxt = {sgn, 8'hff, 23'b0};
    end else begin
      res_nxt = {sgn, mag};
    end
  end

  logic             vc_r;
  logic [31:0]      res_r;
  logic [TAG_W-1:0] tag_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
    if (en) begin
      res_r   <= res_nxt;
      tag_c_r <= tag_b_r;
    end
  end

  assign out_valid = vc_r;
  assign sum       = res_r;
  assign out_tag   = tag_c_r;

endmodule

/* rtl/core/bf16lt_checker.sv */
// Port-level checker for the bf16 log table block, bound to the top level.
module bf16lt_checker import bf16lt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_log_bits,
  input logic        out_out_of_range
);

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_log_bits == 16'b0)
    else $error("out-of-range result with nonzero log bits");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output register empty");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> in_ready)
    else $error("input stalled while output beat drains");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_log_bits)
                                && $stable(out_out_of_range))
    else $error("stalled output beat changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind bf16_log_two_table_sum bf16lt_checker u_bf16lt_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_log_bits(out_log_bits),
  .out_out_of_range(out_out_of_range)
);
